// ===== design/lcpi_pkg.sv =====
package lcpi_pkg;

    localparam int NumLevels = 6;

    localparam logic [2:0] TopLevel  = (NumLevels > 7) ? 3'd7 : 3'(NumLevels);
    localparam logic [2:0] TableTop  = 3'd6;
    localparam logic [7:0] DutyMax   = 8'd127;

    typedef enum logic [1:0] {
        KIND_PRESS  = 2'd0,
        KIND_HOLD   = 2'd1,
        KIND_SAMPLE = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REG_KP_GAIN       = 3'd0,
        REG_KI_GAIN       = 3'd1,
        REG_OC_CODE       = 3'd2,
        REG_BATT_LOW_TRIP = 3'd3,
        REG_BATT_HIGH_TRIP = 3'd4,
        REG_BATT_LOW_REL  = 3'd5,
        REG_BATT_HIGH_REL = 3'd6,
        REG_TABLE_SPLIT   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] kp_gain;
        logic [15:0] ki_gain;
        logic [9:0]  oc_code;
        logic [9:0]  batt_low_trip;
        logic [9:0]  batt_high_trip;
        logic [9:0]  batt_low_rel;
        logic [9:0]  batt_high_rel;
        logic [9:0]  table_split;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         level;
        logic [7:0]         duty;
        logic signed [31:0] integral;
        logic               batt_fault;
    } state_t;

    function automatic logic [2:0] table_index(input logic [2:0] lv);
        return (lv > TableTop) ? TableTop : lv;
    endfunction

    // duty when battery is at or above the split
    function automatic logic [7:0] duty_high_batt(input logic [2:0] idx);
        case (idx)
            3'd0:    return 8'd1;
            3'd1:    return 8'd2;
            3'd2:    return 8'd5;
            3'd3:    return 8'd15;
            3'd4:    return 8'd30;
            3'd5:    return 8'd40;
            default: return 8'd55;
        endcase
    endfunction

    function automatic logic [7:0] duty_low_batt(input logic [2:0] idx);
        case (idx)
            3'd0:    return 8'd1;
            3'd1:    return 8'd2;
            3'd2:    return 8'd7;
            3'd3:    return 8'd20;
            3'd4:    return 8'd45;
            3'd5:    return 8'd60;
            default: return 8'd70;
        endcase
    endfunction

    // current setpoints in ADC codes
    function automatic logic [8:0] setpoint_code(input logic [2:0] idx);
        case (idx)
            3'd0:    return 9'd0;
            3'd1:    return 9'd5;
            3'd2:    return 9'd41;
            3'd3:    return 9'd102;
            3'd4:    return 9'd152;
            3'd5:    return 9'd203;
            default: return 9'd305;
        endcase
    endfunction

endpackage

// ===== design/lcpi_regs.sv =====
module lcpi_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_addr,
    input  logic [15:0]       cfg_wdata,
    output lcpi_pkg::cfg_t    cfg
);

    lcpi_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp_gain        <= 16'd6449;
            cfg_reg.ki_gain        <= 16'd1773;
            cfg_reg.oc_code        <= 10'd509;
            cfg_reg.batt_low_trip  <= 10'd169;
            cfg_reg.batt_high_trip <= 10'd246;
            cfg_reg.batt_low_rel   <= 10'd177;
            cfg_reg.batt_high_rel  <= 10'd243;
            cfg_reg.table_split    <= 10'd212;
        end else if (cfg_we) begin
            unique case (lcpi_pkg::reg_idx_t'(cfg_addr))
                lcpi_pkg::REG_KP_GAIN:        cfg_reg.kp_gain        <= cfg_wdata;
                lcpi_pkg::REG_KI_GAIN:        cfg_reg.ki_gain        <= cfg_wdata;
                lcpi_pkg::REG_OC_CODE:        cfg_reg.oc_code        <= cfg_wdata[9:0];
                lcpi_pkg::REG_BATT_LOW_TRIP:  cfg_reg.batt_low_trip  <= cfg_wdata[9:0];
                lcpi_pkg::REG_BATT_HIGH_TRIP: cfg_reg.batt_high_trip <= cfg_wdata[9:0];
                lcpi_pkg::REG_BATT_LOW_REL:   cfg_reg.batt_low_rel   <= cfg_wdata[9:0];
                lcpi_pkg::REG_BATT_HIGH_REL:  cfg_reg.batt_high_rel  <= cfg_wdata[9:0];
                lcpi_pkg::REG_TABLE_SPLIT:    cfg_reg.table_split    <= cfg_wdata[9:0];
                default:                      cfg_reg                <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/lcpi_step.sv =====
module lcpi_step (
    input  lcpi_pkg::cfg_t    cfg,
    input  lcpi_pkg::state_t  st,
    input  lcpi_pkg::kind_t   kind,
    input  logic [9:0]        batt_code,
    input  logic [9:0]        curr_code,
    output lcpi_pkg::state_t  st_next,
    output logic              oc_trip
);

    logic [2:0]         sp_idx;
    logic [8:0]         sp;
    logic signed [10:0] err;
    logic signed [27:0] prod_i;
    logic signed [27:0] prod_p;
    logic signed [32:0] acc_wide;
    logic signed [31:0] acc_sat;
    logic signed [32:0] pi_sum;
    logic               fold;
    logic [7:0]         duty_pi;
    logic [3:0]         lvl_inc;
    logic [2:0]         inc_idx;
    logic [7:0]         press_duty;
    logic               batt_trip;
    logic               batt_rel;
    logic               proceed;

    // PI loop
    assign sp_idx   = lcpi_pkg::table_index(st.level);
    assign sp       = lcpi_pkg::setpoint_code(sp_idx);
    assign err      = $signed({2'b00, sp}) - $signed({1'b0, curr_code});
    assign prod_i   = $signed({1'b0, cfg.ki_gain}) * err;
    assign prod_p   = $signed({1'b0, cfg.kp_gain}) * err;
    assign acc_wide = 33'(st.integral) + 33'(prod_i);

    always_comb begin
        case (acc_wide[32:31])
            2'b01:   acc_sat = 32'sh7FFF_FFFF;
            2'b10:   acc_sat = 32'sh8000_0000;
            default: acc_sat = acc_wide[31:0];
        endcase
    end

    assign pi_sum = 33'(prod_p) + 33'(acc_sat);
    assign fold   = (pi_sum <= -33'sd65536);

    always_comb begin
        if (pi_sum[32]) begin
            duty_pi = 8'd0;
        end else if (|pi_sum[31:23]) begin
            duty_pi = lcpi_pkg::DutyMax;
        end else begin
            duty_pi = {1'b0, pi_sum[22:16]};
        end
    end

    // button stepping
    assign lvl_inc    = {1'b0, st.level} + 4'd1;
    assign inc_idx    = lcpi_pkg::table_index(lvl_inc[2:0]);
    assign press_duty = (batt_code >= cfg.table_split) ? lcpi_pkg::duty_high_batt(inc_idx)
                                                       : lcpi_pkg::duty_low_batt(inc_idx);

    // battery window
    assign batt_trip = (batt_code < cfg.batt_low_trip) || (batt_code >= cfg.batt_high_trip);
    assign batt_rel  = (batt_code >= cfg.batt_low_rel) && (batt_code <= cfg.batt_high_rel);

    always_comb begin
        st_next = st;
        oc_trip = 1'b0;
        proceed = 1'b0;
        unique case (kind)
            lcpi_pkg::KIND_PRESS: begin
                if (!st.batt_fault) begin
                    if (lvl_inc > {1'b0, lcpi_pkg::TopLevel}) begin
                        st_next.level    = 3'd0;
                        st_next.duty     = 8'd0;
                        st_next.integral = 32'sd0;
                    end else begin
                        st_next.level = lvl_inc[2:0];
                        st_next.duty  = press_duty;
                    end
                end
            end
            lcpi_pkg::KIND_HOLD: begin
                st_next.level    = 3'd0;
                st_next.duty     = 8'd0;
                st_next.integral = 32'sd0;
            end
            lcpi_pkg::KIND_SAMPLE: begin
                if (!st.batt_fault) begin
                    if (batt_trip) begin
                        st_next.batt_fault = 1'b1;
                        st_next.level      = 3'd0;
                        st_next.duty       = 8'd0;
                    end else begin
                        proceed = 1'b1;
                    end
                end else if (batt_rel) begin
                    st_next.batt_fault = 1'b0;
                    proceed            = 1'b1;
                end else begin
                    st_next.level = 3'd0;
                    st_next.duty  = 8'd0;
                end
                if (proceed) begin
                    if (st.level > 3'd1) begin
                        st_next.integral = acc_sat;
                        st_next.duty     = fold ? 8'd0 : duty_pi;
                        st_next.level    = fold ? st.level - 3'd1 : st.level;
                    end
                    if (st_next.level == 3'd0) begin
                        st_next.duty = 8'd0;
                    end
                    if (curr_code >= cfg.oc_code) begin
                        oc_trip       = 1'b1;
                        st_next.duty  = 8'd0;
                        st_next.level = 3'd0;
                    end
                end
            end
            lcpi_pkg::KIND_NONE: begin
                st_next = st;
            end
            default: begin
                st_next = st;
            end
        endcase
    end

endmodule

// ===== design/led_current_pi_level_controller.sv =====
// Throughput: one item per cycle unless m_ready holds the result register;
// input register, one pass of step logic that updates the controller state,
// then the result register.
// Reset (aresetn, synchronous, active low): level, duty, integral and battery
// fault cleared, configuration registers back to defaults, both stages empty.
module led_current_pi_level_controller (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [9:0]  s_batt_code,
    input  logic [9:0]  s_curr_code,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_duty,
    output logic [2:0]  m_level_now,
    output logic        m_batt_fault,
    output logic        m_overcurrent_fault
);

    lcpi_pkg::cfg_t    cfg;
    lcpi_pkg::state_t  state_reg;
    lcpi_pkg::state_t  state_next;
    logic              oc_next;

    logic              in_valid_reg;
    lcpi_pkg::kind_t   in_kind_reg;
    logic [9:0]        in_batt_reg;
    logic [9:0]        in_curr_reg;

    logic              out_valid_reg;
    logic [7:0]        out_duty_reg;
    logic [2:0]        out_level_reg;
    logic              out_fault_reg;
    logic              out_oc_reg;

    logic              advance;

    lcpi_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lcpi_step u_step (
        .cfg       (cfg),
        .st        (state_reg),
        .kind      (in_kind_reg),
        .batt_code (in_batt_reg),
        .curr_code (in_curr_reg),
        .st_next   (state_next),
        .oc_trip   (oc_next)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= lcpi_pkg::kind_t'(s_kind);
            in_batt_reg <= s_batt_code;
            in_curr_reg <= s_curr_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_duty_reg  <= state_next.duty;
            out_level_reg <= state_next.level;
            out_fault_reg <= state_next.batt_fault;
            out_oc_reg    <= oc_next;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_duty              = out_duty_reg;
    assign m_level_now         = out_level_reg;
    assign m_batt_fault        = out_fault_reg;
    assign m_overcurrent_fault = out_oc_reg;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int WatchdogLimit = 4000;
    localparam int MaxReports = 10;
    localparam longint IntegMax = 64'sd2147483647;
    localparam longint IntegMin = -64'sd2147483648;
    localparam logic [6:0][7:0] DutyHiBatt = {8'd55, 8'd40, 8'd30, 8'd15, 8'd5, 8'd2, 8'd1};
    localparam logic [6:0][7:0] DutyLoBatt = {8'd70, 8'd60, 8'd45, 8'd20, 8'd7, 8'd2, 8'd1};
    localparam logic [6:0][8:0] SetpointCode =
        {9'd305, 9'd203, 9'd152, 9'd102, 9'd41, 9'd5, 9'd0};

    typedef struct packed {
        logic [7:0] duty;
        logic [2:0] level;
        logic       batt_fault;
        logic       overcurrent;
    } led_out_t;

    typedef struct packed {
        lcpi_pkg::kind_t kind;
        logic [9:0]      batt;
        logic [9:0]      curr;
        logic            typed;
        led_out_t        want;
    } dir_row_t;

    typedef enum {RX_FREE, RX_COIN, RX_BURSTY, RX_SLOW} rx_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = lcpi_pkg::KIND_NONE;
    logic [9:0]  s_batt_code = '0;
    logic [9:0]  s_curr_code = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_duty;
    logic [2:0]  m_level_now;
    logic        m_batt_fault;
    logic        m_overcurrent_fault;

    // controller copy kept alongside the block
    lcpi_pkg::cfg_t ctl_cfg;
    int          ctl_level;
    logic [7:0]  ctl_duty;
    int          ctl_integral;
    logic        ctl_fault;

    led_out_t    expected_q[$];
    dir_row_t    directed_rows[$];
    int          bad_results = 0;
    int          live_items = 0;
    int          burst_left = 0;
    bit          steady_phase = 1'b0;
    int          idle_cycles = 0;
    rx_mode_t    rx_mode = RX_FREE;
    int          rx_hold = 0;
    int          rx_stall = 0;

    led_current_pi_level_controller DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_addr            (cfg_addr),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_kind              (s_kind),
        .s_batt_code         (s_batt_code),
        .s_curr_code         (s_curr_code),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_duty              (m_duty),
        .m_level_now         (m_level_now),
        .m_batt_fault        (m_batt_fault),
        .m_overcurrent_fault (m_overcurrent_fault)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int table_slot(int lv);
        return (lv > 6) ? 6 : lv;
    endfunction

    function automatic led_out_t advance_controller(lcpi_pkg::kind_t kind, logic [9:0] batt,
                                                    logic [9:0] curr);
        led_out_t r;
        bit       run_loop;
        int       idx;
        longint   err;
        longint   acc;
        longint   sum;
        r.overcurrent = 1'b0;
        case (kind)
            lcpi_pkg::KIND_PRESS: begin
                if (!ctl_fault) begin
                    if (ctl_level + 1 > int'(lcpi_pkg::TopLevel)) begin
                        ctl_level = 0;
                        ctl_duty = '0;
                        ctl_integral = 0;
                    end else begin
                        ctl_level++;
                        idx = table_slot(ctl_level);
                        ctl_duty = (batt >= ctl_cfg.table_split) ? DutyHiBatt[idx]
                                                                 : DutyLoBatt[idx];
                    end
                end
            end
            lcpi_pkg::KIND_HOLD: begin
                ctl_level = 0;
                ctl_duty = '0;
                ctl_integral = 0;
            end
            lcpi_pkg::KIND_SAMPLE: begin
                run_loop = 1'b1;
                if (!ctl_fault) begin
                    if (batt < ctl_cfg.batt_low_trip || batt >= ctl_cfg.batt_high_trip) begin
                        ctl_fault = 1'b1;
                        ctl_level = 0;
                        ctl_duty = '0;
                        run_loop = 1'b0;
                    end
                end else if (batt >= ctl_cfg.batt_low_rel && batt <= ctl_cfg.batt_high_rel) begin
                    ctl_fault = 1'b0;
                end else begin
                    ctl_level = 0;
                    ctl_duty = '0;
                    run_loop = 1'b0;
                end
                if (run_loop) begin
                    if (ctl_level > 1) begin
                        idx = table_slot(ctl_level);
                        err = longint'(SetpointCode[idx]) - longint'(curr);
                        acc = longint'(ctl_integral) + longint'(ctl_cfg.ki_gain) * err;
                        if (acc > IntegMax) acc = IntegMax;
                        if (acc < IntegMin) acc = IntegMin;
                        ctl_integral = int'(acc);
                        sum = longint'(ctl_cfg.kp_gain) * err + acc;
                        if (sum <= -65536) begin
                            ctl_level--;
                            ctl_duty = '0;
                        end else if (sum < 0) begin
                            ctl_duty = '0;
                        end else begin
                            ctl_duty = (sum >= 128 * 65536) ? lcpi_pkg::DutyMax
                                                            : 8'(sum >>> 16);
                        end
                    end
                    if (ctl_level == 0) ctl_duty = '0;
                    if (curr >= ctl_cfg.oc_code) begin
                        r.overcurrent = 1'b1;
                        ctl_duty = '0;
                        ctl_level = 0;
                    end
                end
            end
            lcpi_pkg::KIND_NONE: ;
        endcase
        r.duty = ctl_duty;
        r.level = 3'(ctl_level);
        r.batt_fault = ctl_fault;
        return r;
    endfunction

    task automatic add_row(lcpi_pkg::kind_t kind, int batt, int curr, bit typed,
                           int duty, int level, bit fault, bit oc);
        dir_row_t row;
        row.kind = kind;
        row.batt = 10'(batt);
        row.curr = 10'(curr);
        row.typed = typed;
        row.want = {8'(duty), 3'(level), fault, oc};
        directed_rows.push_back(row);
    endtask

    task automatic send_item(lcpi_pkg::kind_t kind, logic [9:0] batt, logic [9:0] curr,
                             bit typed, led_out_t want);
        int       gap;
        bit       fault_before;
        led_out_t got;
        if (burst_left == 0) begin
            gap = steady_phase ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_kind <= kind;
        s_batt_code <= batt;
        s_curr_code <= curr;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        fault_before = ctl_fault;
        got = advance_controller(kind, batt, curr);
        expected_q.push_back(typed ? want : got);
        if (!(kind == lcpi_pkg::KIND_NONE ||
              (kind == lcpi_pkg::KIND_PRESS && fault_before))) live_items++;
    endtask

    // hold the input side until every transfer in flight has come back
    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_settings(lcpi_pkg::cfg_t c);
        logic [15:0] value;
        for (int i = 0; i < 8; i++) begin
            case (lcpi_pkg::reg_idx_t'(i))
                lcpi_pkg::REG_KP_GAIN:        value = c.kp_gain;
                lcpi_pkg::REG_KI_GAIN:        value = c.ki_gain;
                lcpi_pkg::REG_OC_CODE:        value = 16'(c.oc_code);
                lcpi_pkg::REG_BATT_LOW_TRIP:  value = 16'(c.batt_low_trip);
                lcpi_pkg::REG_BATT_HIGH_TRIP: value = 16'(c.batt_high_trip);
                lcpi_pkg::REG_BATT_LOW_REL:   value = 16'(c.batt_low_rel);
                lcpi_pkg::REG_BATT_HIGH_REL:  value = 16'(c.batt_high_rel);
                lcpi_pkg::REG_TABLE_SPLIT:    value = 16'(c.table_split);
            endcase
            cfg_we <= 1'b1;
            cfg_addr <= lcpi_pkg::reg_idx_t'(i);
            cfg_wdata <= value;
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        ctl_cfg = c;
    endtask

    // mostly inside the window that keeps the loop running
    function automatic logic [9:0] pick_batt();
        int lo;
        int hi;
        if ($urandom_range(0, 9) == 0) return 10'($urandom);
        lo = (ctl_cfg.batt_low_trip > ctl_cfg.batt_low_rel) ? int'(ctl_cfg.batt_low_trip)
                                                            : int'(ctl_cfg.batt_low_rel);
        hi = int'(ctl_cfg.batt_high_trip) - 1;
        if (int'(ctl_cfg.batt_high_rel) < hi) hi = int'(ctl_cfg.batt_high_rel);
        if (lo > hi) begin
            lo = ctl_fault ? int'(ctl_cfg.batt_low_rel) : int'(ctl_cfg.batt_low_trip);
            hi = ctl_fault ? int'(ctl_cfg.batt_high_rel) : int'(ctl_cfg.batt_high_trip) - 1;
        end
        if (lo > hi) return 10'($urandom);
        return 10'($urandom_range(hi, lo));
    endfunction

    task automatic play_sequence();
        int         run_len;
        int         curr_mode;
        int         cv;
        logic [9:0] curr;
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 5))
                send_item(lcpi_pkg::kind_t'($urandom_range(0, 3)), 10'($urandom),
                          10'($urandom), 1'b0, '0);
            return;
        end
        if ($urandom_range(0, 1) == 1)
            send_item(lcpi_pkg::KIND_HOLD, 10'($urandom), 10'($urandom), 1'b0, '0);
        repeat ($urandom_range(1, 7))
            send_item(lcpi_pkg::KIND_PRESS, 10'($urandom), 10'($urandom), 1'b0, '0);
        run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 160) : $urandom_range(1, 30);
        curr_mode = $urandom_range(0, 2);
        repeat (run_len) begin
            if ($urandom_range(0, 24) == 0) begin
                curr = 10'($urandom_range(1023, ctl_cfg.oc_code));
            end else if (curr_mode == 0) begin
                cv = int'(SetpointCode[table_slot(ctl_level)]) + int'($urandom_range(0, 80)) - 40;
                curr = 10'((cv < 0) ? 0 : cv);
            end else if (curr_mode == 1) begin
                curr = 10'($urandom_range(0, 3));
            end else begin
                curr = 10'($urandom);
            end
            send_item(lcpi_pkg::KIND_SAMPLE, pick_batt(), curr, 1'b0, '0);
        end
    endtask

    // result checker and stall watchdog
    always @(posedge aclk) begin
        led_out_t got;
        led_out_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_duty, m_level_now, m_batt_fault, m_overcurrent_fault};
            if (expected_q.size() == 0) begin
                bad_results++;
                if (bad_results <= MaxReports)
                    $display("unexpected transfer: duty %0d level %0d fault %0b oc %0b",
                             got.duty, got.level, got.batt_fault, got.overcurrent);
            end else begin
                want = expected_q.pop_front();
                if (got.duty !== want.duty || got.level !== want.level ||
                    got.batt_fault !== want.batt_fault ||
                    got.overcurrent !== want.overcurrent) begin
                    bad_results++;
                    if (bad_results <= MaxReports)
                        $display("mismatch: duty %0d/%0d level %0d/%0d fault %0b/%0b oc %0b/%0b",
                                 want.duty, got.duty, want.level, got.level,
                                 want.batt_fault, got.batt_fault,
                                 want.overcurrent, got.overcurrent);
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (rx_hold == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_hold = $urandom_range(50, 400);
        end
        rx_hold--;
        if (rx_stall > 0) begin
            rx_stall--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_FREE:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_BURSTY: begin
                    if ($urandom_range(0, 19) == 0) rx_stall = $urandom_range(1, 25);
                    m_ready <= (rx_stall == 0);
                end
                RX_SLOW:   m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial begin
        lcpi_pkg::cfg_t c;
        int   goal;
        int   n;

        ctl_cfg = {16'd6449, 16'd1773, 10'd509, 10'd169, 10'd246, 10'd177, 10'd243, 10'd212};
        ctl_level = 0;
        ctl_duty = '0;
        ctl_integral = 0;
        ctl_fault = 1'b0;

        add_row(lcpi_pkg::KIND_NONE,     0,    0, 1, 0, 0, 0, 0);
        add_row(lcpi_pkg::KIND_PRESS, 1023,    0, 1, 2, 1, 0, 0);
        add_row(lcpi_pkg::KIND_PRESS,    0,    0, 1, 7, 2, 0, 0);
        add_row(lcpi_pkg::KIND_SAMPLE, 200, 1023, 1, 0, 0, 0, 1);
        add_row(lcpi_pkg::KIND_PRESS,  212,    0, 0, 0, 0, 0, 0);
        repeat (5) add_row(lcpi_pkg::KIND_PRESS, 211, 0, 0, 0, 0, 0, 0);
        add_row(lcpi_pkg::KIND_PRESS,  211,    0, 1, 0, 0, 0, 0);
        add_row(lcpi_pkg::KIND_PRESS, 1023,    0, 0, 0, 0, 0, 0);
        add_row(lcpi_pkg::KIND_PRESS, 1023,    0, 0, 0, 0, 0, 0);
        // foldback by one step
        add_row(lcpi_pkg::KIND_SAMPLE, 200,  508, 0, 0, 0, 0, 0);
        add_row(lcpi_pkg::KIND_SAMPLE, 168,    0, 1, 0, 0, 1, 0);
        add_row(lcpi_pkg::KIND_PRESS, 1023,    0, 1, 0, 0, 1, 0);
        add_row(lcpi_pkg::KIND_SAMPLE, 250,    0, 1, 0, 0, 1, 0);
        add_row(lcpi_pkg::KIND_SAMPLE, 177,    0, 1, 0, 0, 0, 0);
        repeat (3) add_row(lcpi_pkg::KIND_PRESS, 1023, 0, 0, 0, 0, 0, 0);
        add_row(lcpi_pkg::KIND_SAMPLE, 243,    0, 0, 0, 0, 0, 0);
        add_row(lcpi_pkg::KIND_SAMPLE, 200,  509, 1, 0, 0, 0, 1);
        add_row(lcpi_pkg::KIND_SAMPLE, 246,    0, 1, 0, 0, 1, 0);
        add_row(lcpi_pkg::KIND_HOLD,     0,    0, 1, 0, 0, 1, 0);
        add_row(lcpi_pkg::KIND_SAMPLE, 243, 1023, 1, 0, 0, 0, 1);
        add_row(lcpi_pkg::KIND_HOLD,     0,    0, 1, 0, 0, 0, 0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].kind, directed_rows[i].batt, directed_rows[i].curr,
                      directed_rows[i].typed, directed_rows[i].want);

        for (int ph = 0; ph < 8; ph++) begin
            n = 190;
            case (ph)
                0: c = {16'd6449, 16'd1773, 10'd509, 10'd169, 10'd246, 10'd177, 10'd243, 10'd212};
                1: c = {16'd0, 16'd0, 10'd0, 10'd0, 10'd1023, 10'd0, 10'd1023, 10'd0};
                2: begin
                    c = {16'd65535, 16'd65535, 10'd1023, 10'd0, 10'd1023, 10'd0, 10'd1023,
                         10'd1023};
                    n = 300;
                end
                3: begin
                    // window that can never release
                    c = {16'd65535, 16'd0, 10'd1023, 10'd1023, 10'd0, 10'd1023, 10'd0, 10'd512};
                    n = 60;
                end
                default: begin
                    c.kp_gain = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(0, 12000));
                    c.ki_gain = 16'($urandom_range(0, 8191));
                    c.oc_code = 10'($urandom_range(300, 1023));
                    c.batt_low_trip = 10'($urandom_range(100, 250));
                    c.batt_high_trip = 10'($urandom_range(c.batt_low_trip + 10,
                                                          c.batt_low_trip + 200));
                    c.batt_low_rel = 10'($urandom_range(c.batt_low_trip, c.batt_low_trip + 15));
                    c.batt_high_rel = 10'($urandom_range(c.batt_high_trip - 15,
                                                         c.batt_high_trip));
                    c.table_split = 10'($urandom_range(c.batt_low_trip, c.batt_high_trip));
                end
            endcase
            drain();
            load_settings(c);
            steady_phase = ($urandom_range(0, 3) == 0);
            goal = live_items + n;
            while (live_items < goal) play_sequence();
        end

        drain();
        repeat (8) @(posedge aclk);
        if (bad_results == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lcpi_pkg.sv
design/lcpi_regs.sv
design/lcpi_step.sv
design/led_current_pi_level_controller.sv
tb/testbench.sv
